>>> rtl/dlp_pkg.sv
package dlp_pkg;

    localparam int MAX_IN   = 16;
    localparam int MAX_OUT  = 16;
    localparam int VW       = 16;
    localparam int FRAC     = 12;
    localparam int IDX_W    = 4;
    localparam int ADDR_W   = 8;
    localparam int CNT_W    = 5;
    localparam int ACC_W    = 40;
    localparam int P_W      = 28;
    localparam int PROD_W   = 32;

    localparam logic [1:0] ACTION_WEIGHT = 2'd0;
    localparam logic [1:0] ACTION_BIAS   = 2'd1;
    localparam logic [1:0] ACTION_SAMPLE = 2'd2;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_RELU  = 3'd1;
    localparam logic [2:0] ACT_TANH  = 3'd2;
    localparam logic [2:0] ACT_SIG   = 3'd3;
    localparam logic [2:0] ACT_LEAKY = 3'd4;

    localparam logic [2:0] CFG_ACT      = 3'd0;
    localparam logic [2:0] CFG_IN_CNT   = 3'd1;
    localparam logic [2:0] CFG_OUT_CNT  = 3'd2;
    localparam logic [2:0] CFG_BIAS_EN  = 3'd3;

    typedef enum logic [1:0] {
        CMD_WEIGHT,
        CMD_BIAS,
        CMD_SAMPLE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic                   last;
        logic [ADDR_W-1:0]      index;
        logic signed [VW-1:0]   data;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         act_mode;
        logic [CNT_W-1:0]   in_cnt;
        logic [CNT_W-1:0]   out_cnt;
        logic               bias_en;
    } cfg_t;

    function automatic logic [CNT_W-1:0] count_clamp(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > CNT_W'(MAX_IN)) begin
            r = CNT_W'(MAX_IN);
        end
        return r;
    endfunction

    function automatic logic [11:0] sig_entry(input logic [4:0] i);
        logic [11:0] r;
        case (i)
            5'd0:    r = 12'd2048;
            5'd1:    r = 12'd2550;
            5'd2:    r = 12'd2994;
            5'd3:    r = 12'd3349;
            5'd4:    r = 12'd3608;
            5'd5:    r = 12'd3785;
            5'd6:    r = 12'd3902;
            5'd7:    r = 12'd3976;
            5'd8:    r = 12'd4022;
            5'd9:    r = 12'd4051;
            5'd10:   r = 12'd4069;
            5'd11:   r = 12'd4079;
            5'd12:   r = 12'd4086;
            5'd13:   r = 12'd4090;
            5'd14:   r = 12'd4092;
            5'd15:   r = 12'd4094;
            default: r = 12'd4095;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/dense_layer_per_pixel.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_action, s_entry_index, s_data_value
// m_        out        m_valid/m_ready    m_result_value, m_last_output
// cfg_      in         cfg_we             cfg_index, cfg_data
//
// The back end stores weight, bias and non-final sample items as it pops them.
// The final sample of a pixel starts a pass over every output, in which the single
// multiply-accumulate unit reads one weight per cycle; the queue is not popped.
// Reset is synchronous and clears control state only; weight and bias stores
// hold undefined data until written. A two-entry queue and an output register
// let input and output stall independently.
module dense_layer_per_pixel (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [dlp_pkg::CNT_W-1:0]       cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_action,
    input  logic [dlp_pkg::ADDR_W-1:0]      s_entry_index,
    input  logic signed [dlp_pkg::VW-1:0]   s_data_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [dlp_pkg::VW-1:0]   m_result_value,
    output logic                            m_last_output
);

    dlp_pkg::cfg_t cfg_reg;
    dlp_pkg::cmd_t push_cmd, q_head;
    logic push, q_full, q_not_empty, pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.act_mode <= dlp_pkg::ACT_NONE;
            cfg_reg.in_cnt   <= dlp_pkg::CNT_W'(1);
            cfg_reg.out_cnt  <= dlp_pkg::CNT_W'(1);
            cfg_reg.bias_en  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                dlp_pkg::CFG_ACT:     cfg_reg.act_mode <= cfg_data[2:0];
                dlp_pkg::CFG_IN_CNT:  cfg_reg.in_cnt   <= cfg_data;
                dlp_pkg::CFG_OUT_CNT: cfg_reg.out_cnt  <= cfg_data;
                dlp_pkg::CFG_BIAS_EN: cfg_reg.bias_en  <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    dlp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_entry_index (s_entry_index),
        .s_data_value  (s_data_value),
        .in_cnt        (cfg_reg.in_cnt),
        .q_full        (q_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    dlp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    dlp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_last_output  (m_last_output)
    );

endmodule

>>> rtl/dlp_front.sv
module dlp_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_action,
    input  logic [dlp_pkg::ADDR_W-1:0]      s_entry_index,
    input  logic signed [dlp_pkg::VW-1:0]   s_data_value,
    input  logic [dlp_pkg::CNT_W-1:0]       in_cnt,
    input  logic                            q_full,
    output logic                            push,
    output dlp_pkg::cmd_t                   push_cmd
);

    logic [dlp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [dlp_pkg::CNT_W-1:0] nin;
    logic                      accept;
    logic                      last;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign nin     = dlp_pkg::count_clamp(in_cnt);
    assign last    = (cnt_reg + dlp_pkg::CNT_W'(1)) >= nin;

    always_comb begin
        push          = 1'b0;
        cnt_next      = cnt_reg;
        push_cmd.kind = dlp_pkg::CMD_SAMPLE;
        push_cmd.last = 1'b0;
        push_cmd.index = s_entry_index;
        push_cmd.data = s_data_value;
        case (s_action)
            dlp_pkg::ACTION_WEIGHT: begin
                push_cmd.kind = dlp_pkg::CMD_WEIGHT;
                push = accept;
            end
            dlp_pkg::ACTION_BIAS: begin
                push_cmd.kind = dlp_pkg::CMD_BIAS;
                push = accept && (s_entry_index < dlp_pkg::ADDR_W'(dlp_pkg::MAX_OUT));
            end
            dlp_pkg::ACTION_SAMPLE: begin
                push_cmd.kind  = dlp_pkg::CMD_SAMPLE;
                push_cmd.last  = last;
                push_cmd.index = dlp_pkg::ADDR_W'(cnt_reg[dlp_pkg::IDX_W-1:0]);
                push = accept;
                if (accept) begin
                    cnt_next = last ? '0 : cnt_reg + dlp_pkg::CNT_W'(1);
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/dlp_queue.sv
module dlp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  dlp_pkg::cmd_t   push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output dlp_pkg::cmd_t   head
);

    dlp_pkg::cmd_t slot_reg [2];
    logic          wp_reg, wp_next;
    logic          rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = slot_reg[rp_reg];

    always_comb begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= push_cmd;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/dlp_back.sv
module dlp_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dlp_pkg::cfg_t                   cfg,
    input  logic                            q_not_empty,
    input  dlp_pkg::cmd_t                   q_head,
    output logic                            pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [dlp_pkg::VW-1:0]   m_result_value,
    output logic                            m_last_output
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ACT1,
        ST_ACT2,
        ST_OUT
    } state_t;

    localparam int LK_W = 18;
    localparam logic [LK_W-1:0] LK_CLAMP = LK_W'(163840);
    localparam logic [LK_W-1:0] LK_RECIP = LK_W'(209716);
    localparam int LKP_W = 2 * LK_W;
    localparam int LK_SHIFT = 20;

    state_t state_reg;
    logic [dlp_pkg::IDX_W-1:0] o_reg, c_reg, c_d_reg;
    logic signed [dlp_pkg::ACC_W-1:0] acc_reg;
    logic rd_vld_reg, prod_vld_reg;
    logic signed [dlp_pkg::VW-1:0] w_rdata_reg;
    logic signed [dlp_pkg::PROD_W-1:0] prod_reg;
    logic signed [dlp_pkg::VW-1:0] wmem [dlp_pkg::MAX_IN*dlp_pkg::MAX_OUT];
    logic signed [dlp_pkg::VW-1:0] bias_reg [dlp_pkg::MAX_OUT];
    logic signed [dlp_pkg::VW-1:0] pix_reg [dlp_pkg::MAX_IN];

    logic signed [dlp_pkg::VW-1:0] satp_reg;
    logic pneg_reg;
    logic [LKP_W-1:0] lk_prod_reg;
    logic [14:0] mag_reg;
    logic big_reg, aneg_reg;
    logic signed [dlp_pkg::VW-1:0] res_reg;
    logic m_valid_reg, m_last_reg;
    logic signed [dlp_pkg::VW-1:0] m_data_reg;

    logic [dlp_pkg::CNT_W-1:0] nin, nout;
    logic mem_we;
    logic [dlp_pkg::ADDR_W-1:0] raddr;
    logic signed [dlp_pkg::ACC_W-1:0] rnd;
    logic signed [dlp_pkg::P_W-1:0] p;
    logic signed [dlp_pkg::VW-1:0] satp;
    logic [dlp_pkg::P_W-1:0] pmag;
    logic [LK_W-1:0] lk_x;
    logic signed [dlp_pkg::P_W-1:0] pcl;
    logic signed [dlp_pkg::P_W-1:0] a;
    logic [dlp_pkg::P_W-1:0] amag;
    logic [11:0] lo, hi, s;
    logic [8:0] dif;
    logic [19:0] interp;
    logic signed [13:0] sg;
    logic signed [14:0] th;
    logic [16:0] lk_q;
    logic signed [dlp_pkg::VW-1:0] res;
    logic out_free;

    assign nin     = dlp_pkg::count_clamp(cfg.in_cnt);
    assign nout    = dlp_pkg::count_clamp(cfg.out_cnt);
    assign pop     = (state_reg == ST_IDLE) && q_not_empty;
    assign mem_we  = pop && (q_head.kind == dlp_pkg::CMD_WEIGHT);
    assign raddr   = {o_reg, c_reg};
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_data_reg;
    assign m_last_output  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            wmem[q_head.index] <= q_head.data;
        end
        w_rdata_reg <= wmem[raddr];
    end

    always_comb begin
        rnd  = acc_reg + dlp_pkg::ACC_W'(2048);
        p    = dlp_pkg::P_W'(rnd >>> dlp_pkg::FRAC);
        if (p > dlp_pkg::P_W'(32767)) begin
            satp = 16'sh7fff;
        end else if (p < -dlp_pkg::P_W'(32768)) begin
            satp = -16'sh8000;
        end else begin
            satp = dlp_pkg::VW'(p);
        end
        pmag = p[dlp_pkg::P_W-1] ? dlp_pkg::P_W'(-p) : dlp_pkg::P_W'(p);
        if (pmag > dlp_pkg::P_W'(LK_CLAMP)) begin
            lk_x = LK_CLAMP + LK_W'(2);
        end else begin
            lk_x = pmag[LK_W-1:0] + LK_W'(2);
        end
        if (p > dlp_pkg::P_W'(1 << 20)) begin
            pcl = dlp_pkg::P_W'(1 << 20);
        end else if (p < -dlp_pkg::P_W'(1 << 20)) begin
            pcl = -dlp_pkg::P_W'(1 << 20);
        end else begin
            pcl = p;
        end
        a    = (cfg.act_mode == dlp_pkg::ACT_TANH) ? (pcl <<< 1) : p;
        amag = a[dlp_pkg::P_W-1] ? dlp_pkg::P_W'(-a) : dlp_pkg::P_W'(a);

        lo     = dlp_pkg::sig_entry({1'b0, mag_reg[14:11]});
        hi     = dlp_pkg::sig_entry(5'({1'b0, mag_reg[14:11]} + 5'd1));
        dif    = 9'(hi - lo);
        interp = 20'(dif) * 20'(mag_reg[10:0]) + 20'd1024;
        s      = big_reg ? 12'd4095 : 12'(lo + 12'(interp >> 11));
        sg     = aneg_reg ? 14'(14'sd4096 - 14'(s)) : 14'(s);
        th     = 15'(sg <<< 1) - 15'sd4096;
        lk_q   = 17'(lk_prod_reg >> LK_SHIFT);
        case (cfg.act_mode)
            dlp_pkg::ACT_RELU:  res = satp_reg[dlp_pkg::VW-1] ? '0 : satp_reg;
            dlp_pkg::ACT_TANH:  res = dlp_pkg::VW'(th);
            dlp_pkg::ACT_SIG:   res = dlp_pkg::VW'(sg);
            dlp_pkg::ACT_LEAKY: res = pneg_reg ? dlp_pkg::VW'(-$signed({1'b0, lk_q}))
                                               : satp_reg;
            default:            res = satp_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pop && q_head.kind == dlp_pkg::CMD_BIAS) begin
            bias_reg[q_head.index[dlp_pkg::IDX_W-1:0]] <= q_head.data;
        end
        if (pop && q_head.kind == dlp_pkg::CMD_SAMPLE) begin
            pix_reg[q_head.index[dlp_pkg::IDX_W-1:0]] <= q_head.data;
        end
        prod_reg    <= pix_reg[c_d_reg] * w_rdata_reg;
        satp_reg    <= satp;
        pneg_reg    <= p[dlp_pkg::P_W-1];
        lk_prod_reg <= LKP_W'(lk_x) * LKP_W'(LK_RECIP);
        mag_reg     <= amag[14:0];
        big_reg     <= amag >= dlp_pkg::P_W'(32768);
        aneg_reg    <= a[dlp_pkg::P_W-1];
        if (state_reg == ST_ACT2) begin
            res_reg <= res;
        end
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            o_reg        <= '0;
            c_reg        <= '0;
            c_d_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
            m_valid_reg  <= 1'b0;
            m_last_reg   <= 1'b0;
            m_data_reg   <= '0;
        end else begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= rd_vld_reg;
            if (prod_vld_reg) begin
                acc_reg <= acc_reg + dlp_pkg::ACC_W'(prod_reg);
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (pop && q_head.kind == dlp_pkg::CMD_SAMPLE && q_head.last) begin
                        o_reg <= '0;
                        c_reg <= '0;
                        acc_reg <= cfg.bias_en
                            ? (dlp_pkg::ACC_W'(bias_reg[0]) <<< dlp_pkg::FRAC) : '0;
                        state_reg <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    rd_vld_reg <= 1'b1;
                    c_d_reg    <= c_reg;
                    if ({1'b0, c_reg} == nin - dlp_pkg::CNT_W'(1)) begin
                        c_reg     <= '0;
                        state_reg <= ST_DRAIN;
                    end else begin
                        c_reg <= c_reg + dlp_pkg::IDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!rd_vld_reg && !prod_vld_reg) begin
                        state_reg <= ST_ACT1;
                    end
                end
                ST_ACT1: begin
                    state_reg <= ST_ACT2;
                end
                ST_ACT2: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        m_last_reg  <= {1'b0, o_reg} == nout - dlp_pkg::CNT_W'(1);
                        if ({1'b0, o_reg} == nout - dlp_pkg::CNT_W'(1)) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            o_reg <= o_reg + dlp_pkg::IDX_W'(1);
                            acc_reg <= cfg.bias_en
                                ? (dlp_pkg::ACC_W'(bias_reg[o_reg + dlp_pkg::IDX_W'(1)])
                                   <<< dlp_pkg::FRAC) : '0;
                            state_reg <= ST_MAC;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/dlp_checker.sv
module dlp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic signed [dlp_pkg::VW-1:0]   m_result_value,
    input logic                            m_last_output
);

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result item valid right after reset");

    assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value)
            && $stable(m_last_output))
        else $error("stalled result item changed");

endmodule

bind dense_layer_per_pixel dlp_checker u_dlp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_last_output  (m_last_output)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] ACTION_NONE = 2'd3;
    localparam logic [2:0] CFG_UNUSED = 3'd5;
    localparam int DRAIN_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic signed [dlp_pkg::VW-1:0] value;
        logic                          last;
    } pixel_out_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [2:0]                      cfg_index = dlp_pkg::CFG_ACT;
    logic [dlp_pkg::CNT_W-1:0]       cfg_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [1:0]                      s_action = dlp_pkg::ACTION_WEIGHT;
    logic [dlp_pkg::ADDR_W-1:0]      s_entry_index = '0;
    logic signed [dlp_pkg::VW-1:0]   s_data_value = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic signed [dlp_pkg::VW-1:0]   m_result_value;
    logic                            m_last_output;

    logic signed [dlp_pkg::VW-1:0] weight_mem [dlp_pkg::MAX_IN*dlp_pkg::MAX_OUT];
    logic signed [dlp_pkg::VW-1:0] bias_mem [dlp_pkg::MAX_OUT];
    logic signed [dlp_pkg::VW-1:0] sample_mem [dlp_pkg::MAX_IN];
    int unsigned                   channel_pos = 0;
    logic [2:0]                    act_sel = dlp_pkg::ACT_NONE;
    logic [dlp_pkg::CNT_W-1:0]     in_sel = 5'd1;
    logic [dlp_pkg::CNT_W-1:0]     out_sel = 5'd1;
    logic                          bias_sel = 1'b0;

    pixel_out_t pending_outputs[$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    bit         steady = 1'b0;

    dense_layer_per_pixel dut (.*);

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 6);
    end

    function automatic logic signed [dlp_pkg::VW-1:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return dlp_pkg::VW'(v);
    endfunction

    function automatic longint sigmoid_pos(longint a);
        longint lo, hi, frac;
        int idx;
        if (a >= 32768) return 4095;
        idx = int'(a >>> 11);
        frac = a & 2047;
        lo = longint'(dlp_pkg::sig_entry(5'(idx)));
        hi = longint'(dlp_pkg::sig_entry(5'(idx + 1)));
        return lo + ((((hi - lo) * frac) + 1024) >>> 11);
    endfunction

    function automatic longint sigmoid_any(longint a);
        if (a >= 0) return sigmoid_pos(a);
        return 4096 - sigmoid_pos(-a);
    endfunction

    function automatic logic signed [dlp_pkg::VW-1:0] activated(longint p);
        case (act_sel)
            dlp_pkg::ACT_RELU: return clamp16(p > 0 ? p : 0);
            dlp_pkg::ACT_TANH: begin
                if (p > (64'sd1 << 20)) p = 64'sd1 << 20;
                if (p < -(64'sd1 << 20)) p = -(64'sd1 << 20);
                return clamp16(2 * sigmoid_any(2 * p) - 4096);
            end
            dlp_pkg::ACT_SIG: return clamp16(sigmoid_any(p));
            dlp_pkg::ACT_LEAKY: begin
                if (p >= 0) return clamp16(p);
                return clamp16(-((-p + 2) / 5));
            end
            default: return clamp16(p);
        endcase
    endfunction

    task automatic predict_item(logic [1:0] action, logic [dlp_pkg::ADDR_W-1:0] idx,
                                logic signed [dlp_pkg::VW-1:0] data);
        int nin, nout;
        longint acc, pre;
        pixel_out_t r;
        if (action == dlp_pkg::ACTION_WEIGHT) begin
            weight_mem[idx] = data;
        end else if (action == dlp_pkg::ACTION_BIAS) begin
            if (idx < dlp_pkg::MAX_OUT) bias_mem[idx] = data;
        end else if (action == dlp_pkg::ACTION_SAMPLE) begin
            nin = (in_sel == 0) ? 1
                : ((int'(in_sel) > dlp_pkg::MAX_IN) ? dlp_pkg::MAX_IN : int'(in_sel));
            nout = (out_sel == 0) ? 1
                : ((int'(out_sel) > dlp_pkg::MAX_OUT) ? dlp_pkg::MAX_OUT : int'(out_sel));
            if (channel_pos < dlp_pkg::MAX_IN) sample_mem[channel_pos] = data;
            channel_pos++;
            if (channel_pos >= nin) begin
                channel_pos = 0;
                for (int o = 0; o < nout; o++) begin
                    acc = bias_sel ? longint'(bias_mem[o]) * 4096 : 0;
                    for (int c = 0; c < nin; c++)
                        acc += longint'(sample_mem[c])
                            * longint'(weight_mem[o*dlp_pkg::MAX_IN + c]);
                    if (acc >= 0) pre = (acc + 2048) >>> 12;
                    else pre = -((-acc + 2047) >>> 12);
                    r.value = activated(pre);
                    r.last = (o + 1 == nout);
                    pending_outputs.push_back(r);
                end
            end
        end
    endtask

    task automatic send_item(logic [1:0] action, logic [dlp_pkg::ADDR_W-1:0] idx,
                             logic signed [dlp_pkg::VW-1:0] data);
        @(negedge aclk);
        if (!steady && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= action;
        s_entry_index <= idx;
        s_data_value <= data;
        do @(posedge aclk); while (!s_ready);
        predict_item(action, idx, data);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [dlp_pkg::CNT_W-1:0] data);
        @(negedge aclk);
        s_valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            dlp_pkg::CFG_ACT: act_sel = data[2:0];
            dlp_pkg::CFG_IN_CNT: in_sel = data;
            dlp_pkg::CFG_OUT_CNT: out_sel = data;
            dlp_pkg::CFG_BIAS_EN: bias_sel = data[0];
            default: ;
        endcase
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_layer(logic [2:0] act, logic [dlp_pkg::CNT_W-1:0] nin,
                             logic [dlp_pkg::CNT_W-1:0] nout, logic bias_on);
        settle();
        write_reg(dlp_pkg::CFG_ACT, dlp_pkg::CNT_W'(act));
        write_reg(dlp_pkg::CFG_IN_CNT, nin);
        write_reg(dlp_pkg::CFG_OUT_CNT, nout);
        write_reg(dlp_pkg::CFG_BIAS_EN, dlp_pkg::CNT_W'(bias_on));
    endtask

    function automatic logic signed [dlp_pkg::VW-1:0] rand_value();
        case ($urandom_range(3))
            0: return dlp_pkg::VW'($urandom);
            1: return dlp_pkg::VW'(int'($urandom_range(2047)) - 1024);
            2: return dlp_pkg::VW'(int'($urandom_range(8191)) - 4096);
            default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    // Rows 0 to 2 are loaded in full and every other row in its first column.
    task automatic test_load_stores();
        for (int o = 0; o < 3; o++)
            for (int c = 0; c < dlp_pkg::MAX_IN; c++)
                send_item(dlp_pkg::ACTION_WEIGHT, dlp_pkg::ADDR_W'(o*dlp_pkg::MAX_IN + c),
                          dlp_pkg::VW'(int'($urandom_range(4095)) - 2048));
        for (int o = 3; o < dlp_pkg::MAX_OUT; o++)
            send_item(dlp_pkg::ACTION_WEIGHT, dlp_pkg::ADDR_W'(o*dlp_pkg::MAX_IN),
                      dlp_pkg::VW'(int'($urandom_range(4095)) - 2048));
        for (int i = 0; i < dlp_pkg::MAX_OUT; i++)
            send_item(dlp_pkg::ACTION_BIAS, dlp_pkg::ADDR_W'(i),
                      dlp_pkg::VW'(int'($urandom_range(8191)) - 4096));
        send_item(dlp_pkg::ACTION_BIAS, 8'd255, 16'sh7fff);
        send_item(ACTION_NONE, 8'd255, 16'sh8000);
    endtask

    task automatic test_extremes();
        set_layer(dlp_pkg::ACT_NONE, 5'd2, 5'd2, 1'b1);
        send_item(dlp_pkg::ACTION_WEIGHT, 8'd0, 16'sh8000);
        send_item(dlp_pkg::ACTION_WEIGHT, 8'd1, 16'sh8000);
        send_item(dlp_pkg::ACTION_WEIGHT, 8'd16, 16'sh7fff);
        send_item(dlp_pkg::ACTION_WEIGHT, 8'd17, 16'sh7fff);
        send_item(dlp_pkg::ACTION_BIAS, 8'd0, 16'sh8000);
        send_item(dlp_pkg::ACTION_SAMPLE, 8'd0, 16'sh8000);
        send_item(dlp_pkg::ACTION_SAMPLE, 8'd0, 16'sh8000);
        send_item(dlp_pkg::ACTION_SAMPLE, 8'd0, 16'sh7fff);
        send_item(dlp_pkg::ACTION_SAMPLE, 8'd0, 16'sh8000);
    endtask

    task automatic test_activations();
        for (int a = 0; a < 8; a++) begin
            set_layer(3'(a), 5'd1, 5'd4, 1'(a & 1));
            send_item(dlp_pkg::ACTION_SAMPLE, 8'd0, 16'sh1000);
            send_item(dlp_pkg::ACTION_SAMPLE, 8'd0, 16'shf000);
        end
    endtask

    task automatic test_count_limits();
        set_layer(dlp_pkg::ACT_LEAKY, 5'd0, 5'd0, 1'b0);
        send_item(dlp_pkg::ACTION_SAMPLE, 8'd0, 16'sh0800);
        set_layer(dlp_pkg::ACT_SIG, 5'd31, 5'd3, 1'b1);
        write_reg(CFG_UNUSED, 5'd31);
        steady = 1'b1;
        repeat (16) send_item(dlp_pkg::ACTION_SAMPLE, 8'd0, rand_value());
        steady = 1'b0;
        set_layer(dlp_pkg::ACT_RELU, 5'd1, 5'd17, 1'b1);
        repeat (2) send_item(dlp_pkg::ACTION_SAMPLE, 8'd0, rand_value());
    endtask

    task automatic test_shrink_mid_pixel();
        set_layer(dlp_pkg::ACT_TANH, 5'd8, 5'd3, 1'b0);
        repeat (5) send_item(dlp_pkg::ACTION_SAMPLE, 8'd0, rand_value());
        set_layer(dlp_pkg::ACT_TANH, 5'd3, 5'd3, 1'b0);
        send_item(dlp_pkg::ACTION_SAMPLE, 8'd0, rand_value());
    endtask

    task automatic test_random();
        int pick;
        for (int ph = 0; ph < 3; ph++) begin
            set_layer(3'($urandom_range(7)), 5'($urandom_range(31)),
                      5'($urandom_range(3)), 1'($urandom_range(1)));
            for (int n = 0; n < 25; n++) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    send_item(dlp_pkg::ACTION_SAMPLE, 8'($urandom), rand_value());
                else if (pick < 85)
                    send_item(dlp_pkg::ACTION_WEIGHT, 8'($urandom), rand_value());
                else if (pick < 95)
                    send_item(dlp_pkg::ACTION_BIAS, 8'($urandom), rand_value());
                else
                    send_item(ACTION_NONE, 8'($urandom), rand_value());
            end
        end
    endtask

    always @(posedge aclk) begin
        pixel_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output: value %0d last %0b",
                             m_result_value, m_last_output);
            end else begin
                want = pending_outputs.pop_front();
                if (m_result_value !== want.value || m_last_output !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("output mismatch: expected %0d/%0b, got %0d/%0b",
                                 want.value, want.last, m_result_value, m_last_output);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_load_stores();
        test_extremes();
        test_activations();
        test_count_limits();
        test_shrink_mid_pixel();
        test_random();
        settle();
        if (mismatches == 0 && pending_outputs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/dlp_pkg.sv
rtl/dlp_front.sv
rtl/dlp_queue.sv
rtl/dlp_back.sv
rtl/dense_layer_per_pixel.sv
rtl/dlp_checker.sv
sim/testbench.sv
